// ===== hw/rtl/mpd_pkg.sv =====
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int unsigned MaxWidth    = 128;
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned MaxWindow   = 16;

  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned ChanW      = $clog2(MaxChannels);
  localparam int unsigned PhaseW     = $clog2(MaxWindow);
  localparam int unsigned AddrW      = ColW + ChanW;
  localparam int unsigned StoreDepth = MaxWidth * MaxChannels;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam int unsigned DimW  = 8;
  localparam int unsigned ChCfgW = 7;
  localparam int unsigned WinW  = 5;
  localparam int unsigned DataW = 8;

  typedef enum logic [2:0] {
    CfgInputWidth   = 3'd0,
    CfgChannels     = 3'd1,
    CfgWindowHeight = 3'd2,
    CfgWindowWidth  = 3'd3,
    CfgOutHeight    = 3'd4,
    CfgOutWidth     = 3'd5,
    CfgActMin       = 3'd6,
    CfgActMax       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic                    frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] pooled;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [DimW-1:0]         in_width;
    logic [ChCfgW-1:0]       channels;
    logic [WinW-1:0]         win_h;
    logic [WinW-1:0]         win_w;
    logic [DimW-1:0]         out_h;
    logic [DimW-1:0]         out_w;
    logic signed [DataW-1:0] act_min;
    logic signed [DataW-1:0] act_max;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0]        addr;
    logic signed [DataW-1:0] sample;
    logic                    first;
    logic                    emit;
    logic                    last;
  } op_t;

  function automatic logic [DimW-1:0] lim_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxWidth)) r = DimW'(MaxWidth);
    return r;
  endfunction

  function automatic logic [ChCfgW-1:0] lim_chan(logic [ChCfgW-1:0] v);
    logic [ChCfgW-1:0] r;
    r = v;
    if (v == '0) r = ChCfgW'(1);
    else if (v > ChCfgW'(MaxChannels)) r = ChCfgW'(MaxChannels);
    return r;
  endfunction

  function automatic logic [WinW-1:0] lim_win(logic [WinW-1:0] v);
    logic [WinW-1:0] r;
    r = v;
    if (v == '0) r = WinW'(1);
    else if (v > WinW'(MaxWindow)) r = WinW'(MaxWindow);
    return r;
  endfunction

endpackage

// ===== hw/rtl/max_pool_downsample_int8.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload
// in       | in_valid_i / in_ready_o | in_data_i (sample, frame_end)
// out      | out_valid_o / out_ready_i | out_data_o (pooled, last)
// cfg      | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// One element per cycle sustained while the queue is not full; a result passes the queue, the
// back-stage register and the output register. The line store has a read and a write port.
// Reset clears counters, queue pointers and valid flags; line store contents are undefined.
// A stalled output holds an emitting back stage; the four-entry queue absorbs the input side.

module max_pool_downsample_int8 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpd_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  mpd_pkg::cfg_reg_e   cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i
);
  import mpd_pkg::*;

  logic [DimW-1:0]         in_width_q, out_h_q, out_w_q;
  logic [ChCfgW-1:0]       channels_q;
  logic [WinW-1:0]         win_h_q, win_w_q;
  logic signed [DataW-1:0] act_min_q, act_max_q;
  cfg_t                    cfg;

  logic push, full, pop, q_valid;
  op_t  push_op, head_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q <= DimW'(1);
      channels_q <= ChCfgW'(1);
      win_h_q    <= WinW'(2);
      win_w_q    <= WinW'(2);
      out_h_q    <= DimW'(1);
      out_w_q    <= DimW'(1);
      act_min_q  <= -8'sd128;
      act_max_q  <= 8'sd127;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgInputWidth:   in_width_q <= cfg_wdata_i;
        CfgChannels:     channels_q <= cfg_wdata_i[ChCfgW-1:0];
        CfgWindowHeight: win_h_q    <= cfg_wdata_i[WinW-1:0];
        CfgWindowWidth:  win_w_q    <= cfg_wdata_i[WinW-1:0];
        CfgOutHeight:    out_h_q    <= cfg_wdata_i;
        CfgOutWidth:     out_w_q    <= cfg_wdata_i;
        CfgActMin:       act_min_q  <= cfg_wdata_i;
        CfgActMax:       act_max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.in_width = lim_dim(in_width_q);
    cfg.channels = lim_chan(channels_q);
    cfg.win_h    = lim_win(win_h_q);
    cfg.win_w    = lim_win(win_w_q);
    cfg.out_h    = lim_dim(out_h_q);
    cfg.out_w    = lim_dim(out_w_q);
    cfg.act_min  = act_min_q;
    cfg.act_max  = act_max_q;
  end

  mpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .op_o       (push_op),
    .full_i     (full)
  );

  mpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_op)
  );

  mpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/mpd_front.sv =====
`timescale 1ns / 1ps

module mpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpd_pkg::cfg_t    cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mpd_pkg::in_item_t in_data_i,
  output logic             push_o,
  output mpd_pkg::op_t     op_o,
  input  logic             full_i
);
  import mpd_pkg::*;

  logic [DimW-1:0]   out_row_q, out_row_d;
  logic [PhaseW-1:0] row_ph_q, row_ph_d;
  logic [ColW-1:0]   in_col_q, in_col_d;
  logic [PhaseW-1:0] col_ph_q, col_ph_d;
  logic [ColW-1:0]   out_col_q, out_col_d;
  logic [ChanW-1:0]  chan_q, chan_d;

  logic [DimW-1:0]   out_row_c;
  logic [PhaseW-1:0] row_ph_c, col_ph_c;
  logic [ColW-1:0]   in_col_c;
  logic [ChanW-1:0]  chan_c;
  logic [ChCfgW-1:0] chan_n;
  logic [DimW-1:0]   in_col_n;
  logic [WinW-1:0]   col_ph_n, row_ph_n;
  logic              accept, in_area;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    chan_c    = ({1'b0, chan_q} >= cfg_i.channels) ? ChanW'(cfg_i.channels - 1'b1) : chan_q;
    row_ph_c  = ({1'b0, row_ph_q} >= cfg_i.win_h) ? PhaseW'(cfg_i.win_h - 1'b1) : row_ph_q;
    col_ph_c  = ({1'b0, col_ph_q} >= cfg_i.win_w) ? PhaseW'(cfg_i.win_w - 1'b1) : col_ph_q;
    in_col_c  = ({1'b0, in_col_q} >= cfg_i.in_width) ? ColW'(cfg_i.in_width - 1'b1) : in_col_q;
    out_row_c = (out_row_q > cfg_i.out_h) ? cfg_i.out_h : out_row_q;

    in_area = (out_row_c < cfg_i.out_h) && ({1'b0, out_col_q} < cfg_i.out_w);

    op_o.addr   = {out_col_q, chan_c};
    op_o.sample = in_data_i.sample;
    op_o.first  = (row_ph_c == '0) && (col_ph_c == '0);
    op_o.emit   = ({1'b0, row_ph_c} + WinW'(1) == cfg_i.win_h) &&
                  ({1'b0, col_ph_c} + WinW'(1) == cfg_i.win_w);
    op_o.last   = (out_row_c + DimW'(1) == cfg_i.out_h) &&
                  ({1'b0, out_col_q} + DimW'(1) == cfg_i.out_w) &&
                  ({1'b0, chan_c} + ChCfgW'(1) == cfg_i.channels);
    push_o = accept && in_area;

    chan_n   = {1'b0, chan_c} + ChCfgW'(1);
    in_col_n = {1'b0, in_col_c} + DimW'(1);
    col_ph_n = {1'b0, col_ph_c} + WinW'(1);
    row_ph_n = {1'b0, row_ph_c} + WinW'(1);

    chan_d    = chan_c;
    in_col_d  = in_col_c;
    col_ph_d  = col_ph_c;
    out_col_d = out_col_q;
    row_ph_d  = row_ph_c;
    out_row_d = out_row_c;

    if (chan_n >= cfg_i.channels) begin
      chan_d   = '0;
      in_col_d = in_col_n[ColW-1:0];
      col_ph_d = col_ph_n[PhaseW-1:0];
      if (col_ph_n >= cfg_i.win_w) begin
        col_ph_d  = '0;
        out_col_d = out_col_q + ColW'(1);
      end
      if (in_col_n >= cfg_i.in_width) begin
        in_col_d  = '0;
        col_ph_d  = '0;
        out_col_d = '0;
        row_ph_d  = row_ph_n[PhaseW-1:0];
        if (row_ph_n >= cfg_i.win_h) begin
          row_ph_d = '0;
          if (out_row_c < cfg_i.out_h) out_row_d = out_row_c + DimW'(1);
        end
      end
    end else begin
      chan_d = chan_n[ChanW-1:0];
    end

    if (in_data_i.frame_end) begin
      chan_d    = '0;
      in_col_d  = '0;
      col_ph_d  = '0;
      out_col_d = '0;
      row_ph_d  = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_row_q <= '0;
      row_ph_q  <= '0;
      in_col_q  <= '0;
      col_ph_q  <= '0;
      out_col_q <= '0;
      chan_q    <= '0;
    end else if (accept) begin
      out_row_q <= out_row_d;
      row_ph_q  <= row_ph_d;
      in_col_q  <= in_col_d;
      col_ph_q  <= col_ph_d;
      out_col_q <= out_col_d;
      chan_q    <= chan_d;
    end
  end

endmodule

// ===== hw/rtl/mpd_fifo.sv =====
`timescale 1ns / 1ps

module mpd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mpd_pkg::op_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output mpd_pkg::op_t head_o
);
  import mpd_pkg::*;

  op_t                 slot_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + FifoCntW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - FifoCntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/mpd_back.sv =====
`timescale 1ns / 1ps

module mpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpd_pkg::cfg_t     cfg_i,
  input  logic              op_valid_i,
  input  mpd_pkg::op_t      op_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mpd_pkg::out_item_t out_data_o
);
  import mpd_pkg::*;

  logic signed [DataW-1:0] store_q [StoreDepth];
  logic signed [DataW-1:0] rd_q;

  logic                    b_valid_q;
  op_t                     b_op_q;
  logic                    lw_valid_q;
  logic [AddrW-1:0]        lw_addr_q;
  logic signed [DataW-1:0] lw_data_q;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q;

  logic                    out_free, adv_b, fwd;
  logic signed [DataW-1:0] stored, base, max_v, clamp_v;

  assign out_free = !out_valid_q || out_ready_i;
  assign adv_b    = b_valid_q && (out_free || !b_op_q.emit);
  assign pop_o    = op_valid_i && (!b_valid_q || adv_b);

  always_comb begin
    fwd     = lw_valid_q && (lw_addr_q == b_op_q.addr);
    stored  = fwd ? lw_data_q : rd_q;
    base    = b_op_q.first ? cfg_i.act_min : stored;
    max_v   = (b_op_q.sample > base) ? b_op_q.sample : base;
    clamp_v = (max_v < cfg_i.act_min) ? cfg_i.act_min : max_v;
    if (clamp_v > cfg_i.act_max) clamp_v = cfg_i.act_max;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_b && b_op_q.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) store_q[b_op_q.addr] <= max_v;
    if (pop_o) rd_q <= store_q[op_i.addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) b_op_q <= op_i;
    if (adv_b) begin
      lw_addr_q <= b_op_q.addr;
      lw_data_q <= max_v;
    end
    if (adv_b && b_op_q.emit) begin
      out_data_q.pooled <= clamp_v;
      out_data_q.last   <= b_op_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) b_valid_q <= 1'b1;
      else if (adv_b) b_valid_q <= 1'b0;
      if (adv_b) lw_valid_q <= 1'b1;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_adv_needs_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_b |-> b_valid_q)
    else $error("back stage advanced without an operation");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> op_valid_i)
    else $error("queue popped while empty");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && b_valid_q && b_op_q.emit) |-> !adv_b)
    else $error("result emitted over a pending transaction");

  a_bypass_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_b |=> (lw_valid_q && lw_addr_q == $past(b_op_q.addr)))
    else $error("bypass register missed the last store write");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mpd_pkg::*;

  localparam int unsigned ItemTarget = 1000;
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainTail  = 10;

  typedef enum int unsigned {
    XChannels,
    XWinHeight,
    XWinWidth,
    XInWidth,
    XOutHeight
  } extreme_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  cfg_reg_e   cfg_addr_i  = CfgInputWidth;
  logic [7:0] cfg_wdata_i = '0;

  max_pool_downsample_int8 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  in_item_t          sample_q [$];
  out_item_t         pooled_q [$];
  logic [7:0]        regs [8];
  logic signed [7:0] win_max [StoreDepth];
  int unsigned       out_row, row_ph, in_col, col_ph, out_col, chan;
  int unsigned       pushed_total = 0;
  int unsigned       errors = 0;
  int unsigned       cycles = 0;
  int unsigned       send_idle = 14;
  int unsigned       recv_stall = 67;

  function automatic int unsigned clip_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void pool_step(in_item_t it);
    int unsigned       iw, ch, wh, ww, oh, ow, addr;
    logic signed [7:0] amin, amax, m;
    out_item_t         res;
    iw   = clip_reg(regs[CfgInputWidth], MaxWidth);
    ch   = clip_reg(regs[CfgChannels] & 8'h7f, MaxChannels);
    wh   = clip_reg(regs[CfgWindowHeight] & 8'h1f, MaxWindow);
    ww   = clip_reg(regs[CfgWindowWidth] & 8'h1f, MaxWindow);
    oh   = clip_reg(regs[CfgOutHeight], MaxWidth);
    ow   = clip_reg(regs[CfgOutWidth], MaxWidth);
    amin = regs[CfgActMin];
    amax = regs[CfgActMax];
    if (out_row < oh && out_col < ow) begin
      addr = out_col * MaxChannels + chan;
      m = (row_ph == 0 && col_ph == 0) ? amin : win_max[addr];
      if (it.sample > m) m = it.sample;
      win_max[addr] = m;
      if (row_ph + 1 == wh && col_ph + 1 == ww) begin
        if (m < amin) m = amin;
        if (m > amax) m = amax;
        res.pooled = m;
        res.last   = (out_row + 1 == oh && out_col + 1 == ow && chan + 1 == ch);
        pooled_q.push_back(res);
      end
    end
    chan++;
    if (chan >= ch) begin
      chan = 0;
      in_col++;
      col_ph++;
      if (col_ph >= ww) begin
        col_ph = 0;
        out_col++;
      end
      if (in_col >= iw) begin
        in_col  = 0;
        col_ph  = 0;
        out_col = 0;
        row_ph++;
        if (row_ph >= wh) begin
          row_ph = 0;
          if (out_row < oh) out_row++;
        end
      end
    end
    if (it.frame_end) begin
      out_row = 0;
      row_ph  = 0;
      in_col  = 0;
      col_ph  = 0;
      out_col = 0;
      chan    = 0;
    end
  endfunction

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pooled_q.size() == 0) begin
      $display("%0t: unexpected result, expected none got pooled=%0d last=%0b",
               $time, got.pooled, got.last);
      errors++;
    end else begin
      want = pooled_q.pop_front();
      if (got.pooled !== want.pooled) begin
        $display("%0t: pooled mismatch, expected %0d got %0d", $time, want.pooled, got.pooled);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch, expected %0b got %0b", $time, want.last, got.last);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_data_i  <= sample_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) pool_step(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_item(logic signed [7:0] s, bit fe);
    in_item_t it;
    it.sample    = s;
    it.frame_end = fe;
    sample_q.push_back(it);
    pushed_total++;
  endtask

  task automatic push_frame(int unsigned elems, bit broken);
    int unsigned n;
    n = broken ? $urandom_range(1, elems) : elems;
    for (int i = 0; i < n; i++) push_item(8'($urandom), i == n - 1);
  endtask

  task automatic drain(int unsigned tail);
    do @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || pooled_q.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] iw, ch, wh, ww, oh, ow, amin, amax);
    logic [7:0] v [8];
    v[CfgInputWidth]   = iw;
    v[CfgChannels]     = ch;
    v[CfgWindowHeight] = wh;
    v[CfgWindowWidth]  = ww;
    v[CfgOutHeight]    = oh;
    v[CfgOutWidth]     = ow;
    v[CfgActMin]       = amin;
    v[CfgActMax]       = amax;
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= cfg_reg_e'(i);
      cfg_wdata_i <= v[i];
      regs[i] = v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] maybe_zero(int unsigned v);
    return (v == 1 && $urandom_range(1) == 1) ? 8'd0 : 8'(v);
  endfunction

  initial begin
    int unsigned       phase, start, rows;
    int unsigned       iw_e, ch_e, wh_e, ww_e, oh_e, ow_e;
    logic [7:0]        iw_r, ch_r, wh_r, ww_r, oh_r, ow_r;
    logic signed [7:0] amin_r, amax_r, tmp;
    extreme_e          kind;

    regs[CfgInputWidth]   = 8'd1;
    regs[CfgChannels]     = 8'd1;
    regs[CfgWindowHeight] = 8'd2;
    regs[CfgWindowWidth]  = 8'd2;
    regs[CfgOutHeight]    = 8'd1;
    regs[CfgOutWidth]     = 8'd1;
    regs[CfgActMin]       = 8'h80;
    regs[CfgActMax]       = 8'h7f;
    out_row = 0; row_ph = 0; in_col = 0; col_ph = 0; out_col = 0; chan = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_item(8'sd127, 1'b0);
    push_item(-8'sd128, 1'b0);
    push_item(8'sd0, 1'b0);
    push_item(-8'sd1, 1'b1);
    drain(DrainTail);

    write_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'h80, 8'h7f);
    push_item(8'sd127, 1'b0);
    push_item(-8'sd128, 1'b0);
    push_item(8'sd5, 1'b1);
    push_item(-8'sd128, 1'b1);
    drain(DrainTail);

    write_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'sd20, -8'sd20);
    push_item(8'sd100, 1'b1);
    push_item(-8'sd100, 1'b1);
    push_item(8'sd0, 1'b1);
    drain(DrainTail);

    write_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, -8'sd10, 8'sd10);
    push_item(-8'sd50, 1'b1);
    push_item(8'sd50, 1'b1);
    push_item(8'sd3, 1'b1);
    push_item(-8'sd10, 1'b1);
    drain(DrainTail);

    write_config(8'd2, 8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'h80, 8'h7f);
    push_item(8'sd127, 1'b0);
    push_item(-8'sd128, 1'b0);
    push_item(-8'sd128, 1'b0);
    push_item(-8'sd128, 1'b1);
    for (int i = 0; i < 4; i++) push_item(-8'sd128, i == 3);
    drain(DrainTail);

    phase = 0;
    while (pushed_total < ItemTarget) begin
      if (pushed_total < ItemTarget / 3) begin
        send_idle  = 14;
        recv_stall = 67;
      end else if (pushed_total < 2 * ItemTarget / 3) begin
        send_idle  = 67;
        recv_stall = 14;
      end else begin
        send_idle  = 0;
        recv_stall = 0;
      end

      if (phase % 2 == 1) begin
        iw_r = 8'd1; ch_r = 8'd1; wh_r = 8'd1; ww_r = 8'd1; oh_r = 8'd1; ow_r = 8'd1;
        kind = extreme_e'((phase / 2) % 5);
        case (kind)
          XChannels:  ch_r = 8'($urandom_range(64, 127));
          XWinHeight: wh_r = 8'($urandom_range(16, 31));
          XWinWidth: begin
            ww_r = 8'($urandom_range(16, 31));
            iw_r = 8'd16;
          end
          XInWidth: begin
            iw_r = 8'($urandom_range(128, 255));
            ow_r = 8'($urandom_range(128, 255));
          end
          default:    oh_r = 8'($urandom_range(128, 255));
        endcase
      end else begin
        ww_e = $urandom_range(1, 4);
        wh_e = $urandom_range(1, 4);
        ch_e = $urandom_range(1, 3);
        ow_e = $urandom_range(1, 4);
        oh_e = $urandom_range(1, 3);
        iw_e = ($urandom_range(4) == 0) ? $urandom_range(1, 12)
                                        : ow_e * ww_e + $urandom_range(0, 2);
        iw_r = maybe_zero(iw_e);
        ch_r = maybe_zero(ch_e);
        wh_r = maybe_zero(wh_e);
        ww_r = maybe_zero(ww_e);
        oh_r = maybe_zero(oh_e);
        ow_r = maybe_zero(ow_e);
      end

      if ($urandom_range(2) == 0) begin
        amin_r = -8'sd128;
        amax_r = 8'sd127;
      end else begin
        amin_r = 8'($urandom);
        amax_r = 8'($urandom);
        if ($urandom_range(3) != 0 && amin_r > amax_r) begin
          tmp    = amin_r;
          amin_r = amax_r;
          amax_r = tmp;
        end
      end

      write_config(iw_r, ch_r, wh_r, ww_r, oh_r, ow_r, amin_r, amax_r);
      iw_e = clip_reg(iw_r, MaxWidth);
      ch_e = clip_reg(ch_r, MaxChannels);
      wh_e = clip_reg(wh_r, MaxWindow);
      ww_e = clip_reg(ww_r, MaxWindow);
      oh_e = clip_reg(oh_r, MaxWidth);

      start = pushed_total;
      do begin
        rows = oh_e * wh_e + (($urandom_range(3) == 0) ? 1 : 0);
        push_frame(rows * iw_e * ch_e, $urandom_range(6) == 0);
      end while (pushed_total - start < 60);
      drain(DrainTail);
      phase++;
    end

    drain(2 * DrainTail);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
